// File: design/assert_macros.svh
// Assertion macros used by the result sequencer (utf8d_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while in reset.
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in the same cycle implies consequent.
`define UTF8D_ASSERT_IMPL(lbl, ante, cons, msg) \
  `UTF8D_ASSERT(lbl, (ante) |-> (cons), msg)

// Antecedent implies consequent in the next cycle.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  `UTF8D_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: design/utf8d_pkg.sv
// Types and constants shared by the UTF-8 stream decoder modules.
`timescale 1ns / 1ps
package utf8d_pkg;

  localparam logic [20:0] REPL_CP   = 21'h00FFFD;
  localparam int          JOB_DEPTH = 4;
  localparam int          JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int          JOB_CNT_W = $clog2(JOB_DEPTH + 1);
  localparam logic [2:0]  MAX_RESULTS = 3'd4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        bad_sequence;
    logic        run_last;
    logic        text_last;
    logic        text_valid;
  } out_item_t;

  // One classified byte: nrep bad replacements, then an optional tail result.
  typedef struct packed {
    logic [2:0]  nrep;
    logic        tail;
    logic [20:0] tail_cp;
    logic        tail_bad;
    logic        text_end;
    logic        text_valid;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } job_q_status_t;

endpackage

// File: design/utf8d_front.sv
// Front end: accepts bytes, tracks the open sequence and builds result jobs.
`timescale 1ns / 1ps
module utf8d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  utf8d_pkg::in_item_t in_item,
  input  logic               job_full,
  output logic               job_push,
  output utf8d_pkg::job_t    job
);
  import utf8d_pkg::*;

  logic [1:0]  need_r, need_nxt;
  logic [1:0]  held_r, held_nxt;
  logic [20:0] part_r, part_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        fin;
  logic [20:0] new_part;
  logic [1:0]  need_dec;
  logic [2:0]  held_inc;
  logic        fresh;
  logic [2:0]  nrep;
  logic        tail;
  logic [20:0] tail_cp;
  logic        tail_bad;
  logic        fail_now;

  function automatic logic cp_ok(input logic [20:0] cp, input logic [1:0] len_m1);
    logic ok;
    ok = 1'b1;
    if (cp >= 21'h00D800 && cp <= 21'h00DFFF) ok = 1'b0;
    if (cp > 21'h10FFFF) ok = 1'b0;
    if (len_m1 == 2'd1 && cp < 21'h000080) ok = 1'b0;
    if (len_m1 == 2'd2 && cp < 21'h000800) ok = 1'b0;
    if (len_m1 == 2'd3 && cp < 21'h010000) ok = 1'b0;
    return ok;
  endfunction

  assign accept   = in_push && !job_full;
  assign b        = in_item.byte_value;
  assign fin      = in_item.text_end;
  assign new_part = {part_r[14:0], b[5:0]};
  assign need_dec = need_r - 2'd1;
  assign held_inc = {1'b0, held_r} + 3'd1;

  always_comb begin
    need_nxt = need_r;
    held_nxt = held_r;
    part_nxt = part_r;
    fresh    = 1'b0;
    nrep     = 3'd0;
    tail     = 1'b0;
    tail_cp  = REPL_CP;
    tail_bad = 1'b0;

    if (need_r == 2'd0) begin
      fresh = 1'b1;
    end else if (b[7:6] == 2'b10) begin
      if (need_dec == 2'd0) begin
        if (cp_ok(new_part, held_r)) begin
          tail    = 1'b1;
          tail_cp = new_part;
        end else begin
          nrep = held_inc;
        end
        need_nxt = 2'd0;
        held_nxt = 2'd0;
        part_nxt = '0;
      end else if (fin) begin
        nrep     = held_inc;
        need_nxt = 2'd0;
        held_nxt = 2'd0;
        part_nxt = '0;
      end else begin
        need_nxt = need_dec;
        held_nxt = held_inc[1:0];
        part_nxt = new_part;
      end
    end else begin
      // broken sequence: replay held bytes, then decode this byte afresh
      nrep     = {1'b0, held_r};
      need_nxt = 2'd0;
      held_nxt = 2'd0;
      part_nxt = '0;
      fresh    = 1'b1;
    end

    if (fresh) begin
      if (b < 8'h80) begin
        tail    = 1'b1;
        tail_cp = {13'd0, b};
      end else if (b < 8'hC2 || b >= 8'hF5 || fin) begin
        tail     = 1'b1;
        tail_bad = 1'b1;
      end else begin
        held_nxt = 2'd1;
        if (b < 8'hE0) begin
          need_nxt = 2'd1;
          part_nxt = {16'd0, b[4:0]};
        end else if (b < 8'hF0) begin
          need_nxt = 2'd2;
          part_nxt = {17'd0, b[3:0]};
        end else begin
          need_nxt = 2'd3;
          part_nxt = {18'd0, b[2:0]};
        end
      end
    end

    if (fin) begin
      need_nxt = 2'd0;
      held_nxt = 2'd0;
      part_nxt = '0;
    end
  end

  assign fail_now = err_r || (nrep != 3'd0) || tail_bad;
  assign err_nxt  = fin ? 1'b0 : fail_now;

  assign job_push       = accept && ((nrep != 3'd0) || tail);
  assign job.nrep       = nrep;
  assign job.tail       = tail;
  assign job.tail_cp    = tail_cp;
  assign job.tail_bad   = tail_bad;
  assign job.text_end   = fin;
  assign job.text_valid = !fail_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      held_r <= 2'd0;
      part_r <= '0;
      err_r  <= 1'b0;
    end else if (accept) begin
      need_r <= need_nxt;
      held_r <= held_nxt;
      part_r <= part_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

// File: design/utf8d_job_fifo.sv
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module utf8d_job_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  utf8d_pkg::job_t         push_job,
  input  logic                    pop,
  output utf8d_pkg::job_t         head_job,
  output utf8d_pkg::job_q_status_t status
);
  import utf8d_pkg::*;

  job_t                 slots_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOB_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOB_CNT_W-1:0] count_r, count_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign status.full  = (count_r == JOB_CNT_W'(JOB_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: design/utf8d_back.sv
// Result sequencer: expands the head job into one result per transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8d_pkg::job_t      head_job,
  input  logic                 job_empty,
  output logic                 job_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output utf8d_pkg::out_item_t out_item
);
  import utf8d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       last;
  logic       take;

  assign total = head_job.nrep + {2'd0, head_job.tail};
  assign last  = ({1'b0, idx_r} == total - 3'd1);
  assign take  = out_pop && !job_empty;

  assign out_empty = job_empty;
  assign job_pop   = take && last;

  always_comb begin
    if ({1'b0, idx_r} < head_job.nrep) begin
      out_item.code_point   = REPL_CP;
      out_item.bad_sequence = 1'b1;
    end else begin
      out_item.code_point   = head_job.tail_cp;
      out_item.bad_sequence = head_job.tail_bad;
    end
    out_item.run_last   = last;
    out_item.text_last  = last && head_job.text_end;
    out_item.text_valid = last && head_job.text_end && head_job.text_valid;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (take) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `UTF8D_ASSERT_IMPL(a_job_size, !job_empty, total != 3'd0 && total <= MAX_RESULTS, "bad job size")
  `UTF8D_ASSERT_IMPL(a_idx_range, !job_empty, {1'b0, idx_r} < total, "result index past job")
  `UTF8D_ASSERT_NEXT(a_job_held, take && !last, !job_empty && idx_r != 2'd0, "job lost mid-run")

endmodule

// File: design/utf8_stream_decoder_top.sv
// Top level of the UTF-8 stream decoder with replacement.
`timescale 1ns / 1ps
// Input queue side: drive in_item (byte_value, text_end) with in_push; a byte
// is taken on a clock edge with in_push high and in_full low. Mark the last
// byte of each text with text_end.
// Result queue side: while out_empty is low, out_item holds the oldest result
// (code_point, bad_sequence, run_last, text_last, text_valid); it is taken on
// a clock edge with out_pop high. Each byte gives 0 to 4 results; run_last
// flags the last one of a byte, text_last and text_valid mark the end of text.
// A byte's results reach out_item once the jobs ahead of it are popped.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_pop stays high; a byte yielding N results busies the result side
// until the sequencer, emitting one result per cycle while out_pop is high,
// has sent them all. A 4-entry job queue absorbs these bursts before in_full
// rises. A stalled result side fills the job queue, then in_full stays high
// until the head job's last result is popped. Synchronous reset (rst_n low)
// empties the queue and closes any open sequence and text.
module utf8_stream_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  utf8d_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output utf8d_pkg::out_item_t out_item
);
  import utf8d_pkg::*;

  job_t          push_job;
  job_t          head_job;
  logic          job_push;
  logic          job_pop;
  job_q_status_t q_status;

  assign in_full = q_status.full;

  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .job_full (q_status.full),
    .job_push (job_push),
    .job      (push_job)
  );

  utf8d_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .job_empty (q_status.empty),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
